// ----- rtl/fhr_pkg.sv -----
package fhr_pkg;

  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;

  localparam logic [31:0] LCG_MUL = 32'h015a_4e35;
  localparam logic [31:0] LCG_INC = 32'd1;

  localparam int PADDR_W = 4;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_RISE  = 2'd2;
  localparam logic [1:0] OP_SEED  = 2'd3;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DECAY  = 2'd2;

  localparam logic [6:0] WIDTH_RST  = 7'd64;
  localparam logic [6:0] HEIGHT_RST = 7'd64;
  localparam logic [7:0] DECAY_RST  = 8'd12;
  localparam logic [31:0] SEED_RST  = 32'd1;

  localparam int MOD_BITS_PER_CYCLE = 4;

  function automatic logic [1:0] mod3(input logic [31:0] x);
    logic [5:0] s;
    logic [3:0] a;
    s = '0;
    for (int i = 0; i < 16; i++) begin
      s = s + 6'(x[2*i +: 2]);
    end
    a = 4'(s[1:0]) + 4'(s[3:2]) + 4'(s[5:4]);
    if (a >= 4'd6) begin
      a = a - 4'd6;
    end else if (a >= 4'd3) begin
      a = a - 4'd3;
    end
    return a[1:0];
  endfunction

endpackage

// ----- rtl/fhr_in_if.sv -----
interface fhr_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [5:0]        col;
  logic [5:0]        row;
  logic [7:0]        cell_value;
  logic [31:0]       seed_value;
  logic signed [1:0] wind;

  modport source (output valid, operation, col, row, cell_value, seed_value, wind,
                  input ready);
  modport sink (input valid, operation, col, row, cell_value, seed_value, wind,
                output ready);
endinterface

// ----- rtl/fhr_out_if.sv -----
interface fhr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_value;
  logic [31:0] seed_now;

  modport source (output valid, read_value, seed_now, input ready);
  modport sink (input valid, read_value, seed_now, output ready);
endinterface

// ----- rtl/fhr_ram.sv -----
module fhr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/fhr_mod.sv -----
module fhr_mod (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [7:0]  divisor,
  output logic        done,
  output logic [7:0]  rem
);

  localparam int BPC   = fhr_pkg::MOD_BITS_PER_CYCLE;
  localparam int STEPS = 32 / BPC;
  localparam int CW    = $clog2(STEPS + 1);

  logic [31:0]   q_r;
  logic [8:0]    rem_r;
  logic [CW-1:0] cnt_r;
  logic          done_r;
  logic [8:0]    r_nxt;

  always_comb begin
    r_nxt = rem_r;
    for (int i = 0; i < BPC; i++) begin
      r_nxt = {r_nxt[7:0], q_r[31-i]};
      if (r_nxt >= {1'b0, divisor}) begin
        r_nxt = r_nxt - {1'b0, divisor};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CW'(STEPS);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      q_r   <= q_r << BPC;
      rem_r <= r_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r[7:0];

endmodule

// ----- rtl/fire_heat_map_rise.sv -----
// Fire-effect heat map: one item at a time. After reset the map is cleared by a
// pass over all MAX_WIDTH*MAX_HEIGHT cells during which no item is taken. A cell
// write passes the address and memory states, a cell read also the read-data
// state, and a seed load goes from the address state straight to the finish. A
// rise frame walks every cell of rows height-2 down to 0 through the single port
// of the heat memory: a cell that cools clears the cell above, and a cell that
// rises takes three generator steps and the remainder unit for the random loss.
module fire_heat_map_rise #(
  parameter int MAX_WIDTH  = fhr_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = fhr_pkg::MAX_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  fhr_in_if.sink                      in_ch,
  fhr_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fhr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int TW    = AW + 3;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ADDR  = 4'd2;
  localparam logic [3:0] S_MEM   = 4'd3;
  localparam logic [3:0] S_RDAT  = 4'd4;
  localparam logic [3:0] S_FIN   = 4'd5;
  localparam logic [3:0] S_RSTRT = 4'd6;
  localparam logic [3:0] S_RINIT = 4'd7;
  localparam logic [3:0] S_CRD   = 4'd8;
  localparam logic [3:0] S_CHK   = 4'd9;
  localparam logic [3:0] S_L2    = 4'd10;
  localparam logic [3:0] S_L3    = 4'd11;
  localparam logic [3:0] S_DIV   = 4'd12;
  localparam logic [3:0] S_WR    = 4'd13;
  localparam logic [3:0] S_NEXT  = 4'd14;

  logic [3:0]  state_r;
  logic [6:0]  width_cfg_r;
  logic [6:0]  height_cfg_r;
  logic [7:0]  decay_r;
  logic [31:0] seed_r;

  logic [AW-1:0] clr_addr_r;
  logic [1:0]    op_r;
  logic [5:0]    col_r;
  logic [5:0]    row_r;
  logic [7:0]    cval_r;
  logic [31:0]   sval_r;
  logic signed [1:0] wind_r;
  logic [AW-1:0] addr_r;
  logic          inside_r;
  logic [7:0]    rd_r;

  logic [WW-1:0] w_r;
  logic [AW:0]   total_r;
  logic [AW-1:0] rb_r;
  logic [HW-1:0] y_r;
  logic [WW-1:0] c_r;
  logic          pass_r;
  logic [7:0]    v_r;
  logic [1:0]    r3_r;
  logic          r2_r;

  logic          out_valid_r;
  logic [7:0]    out_rd_r;
  logic [31:0]   out_seed_r;

  logic [WW-1:0] w_cur;
  logic [HW-1:0] h_cur;
  logic [WW-1:0] half;
  logic [AW-1:0] here;
  logic [AW-1:0] above;
  logic          edge_c;
  logic          cool;
  logic [31:0]   seed_step;
  logic [TW-1:0] tgt;
  logic          tgt_ok;
  logic [7:0]    loss;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  logic          mod_start;
  logic          mod_done;
  logic [7:0]    mod_rem;

  logic          cfg_wr;

  fhr_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_heat (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  fhr_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (seed_step),
    .divisor  (decay_r),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_comb begin
    if (width_cfg_r < 7'd4) begin
      w_cur = WW'(4);
    end else if (32'(width_cfg_r) > MAX_WIDTH) begin
      w_cur = WW'(MAX_WIDTH);
    end else begin
      w_cur = WW'(width_cfg_r);
    end
    if (height_cfg_r < 7'd2) begin
      h_cur = HW'(2);
    end else if (32'(height_cfg_r) > MAX_HEIGHT) begin
      h_cur = HW'(MAX_HEIGHT);
    end else begin
      h_cur = HW'(height_cfg_r);
    end
  end

  assign half      = w_r >> 1;
  assign here      = rb_r + AW'(c_r);
  assign above     = here + AW'(w_r);
  assign edge_c    = pass_r ? (c_r == w_r - WW'(1)) : (c_r == '0);
  assign cool      = (ram_rdata < decay_r) || edge_c;
  assign seed_step = seed_r * fhr_pkg::LCG_MUL + fhr_pkg::LCG_INC;
  assign loss      = (decay_r == '0) ? 8'd0 : mod_rem;
  assign tgt       = TW'(above) + TW'(1) - TW'(r3_r) + (r2_r ? TW'(wind_r) : '0);
  assign tgt_ok    = tgt < TW'(total_r);
  assign mod_start = (state_r == S_L3);

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = here;
    ram_wdata = '0;
    unique case (state_r)
      S_CLR: begin
        ram_we   = 1'b1;
        ram_addr = clr_addr_r;
      end
      S_MEM: begin
        ram_we    = (op_r == fhr_pkg::OP_WRITE) && inside_r;
        ram_addr  = addr_r;
        ram_wdata = cval_r;
      end
      S_CHK: begin
        ram_we   = cool;
        ram_addr = above;
      end
      S_WR: begin
        ram_we    = tgt_ok;
        ram_addr  = AW'(tgt);
        ram_wdata = v_r - loss;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r  <= fhr_pkg::WIDTH_RST;
      height_cfg_r <= fhr_pkg::HEIGHT_RST;
      decay_r      <= fhr_pkg::DECAY_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        fhr_pkg::REG_WIDTH:  width_cfg_r  <= pwdata[6:0];
        fhr_pkg::REG_HEIGHT: height_cfg_r <= pwdata[6:0];
        fhr_pkg::REG_DECAY:  decay_r      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      fhr_pkg::REG_WIDTH:  prdata = 32'(width_cfg_r);
      fhr_pkg::REG_HEIGHT: prdata = 32'(height_cfg_r);
      fhr_pkg::REG_DECAY:  prdata = 32'(decay_r);
      default:             prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      seed_r      <= fhr_pkg::SEED_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (32'(clr_addr_r) == DEPTH - 1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            state_r <= S_ADDR;
          end
        end
        S_ADDR: begin
          rd_r <= '0;
          unique case (op_r)
            fhr_pkg::OP_RISE: state_r <= S_RSTRT;
            fhr_pkg::OP_SEED: begin
              seed_r  <= sval_r;
              state_r <= S_FIN;
            end
            default: state_r <= S_MEM;
          endcase
        end
        S_MEM: begin
          state_r <= (op_r == fhr_pkg::OP_READ) ? S_RDAT : S_FIN;
        end
        S_RDAT: begin
          if (inside_r) begin
            rd_r <= ram_rdata;
          end
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_RSTRT: begin
          state_r <= S_RINIT;
        end
        S_RINIT: begin
          state_r <= S_CRD;
        end
        S_CRD: begin
          state_r <= S_CHK;
        end
        S_CHK: begin
          if (cool) begin
            state_r <= S_NEXT;
          end else begin
            seed_r  <= seed_step;
            state_r <= S_L2;
          end
        end
        S_L2: begin
          seed_r  <= seed_step;
          state_r <= S_L3;
        end
        S_L3: begin
          seed_r  <= seed_step;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (mod_done) begin
            state_r <= S_WR;
          end
        end
        S_WR: begin
          state_r <= S_NEXT;
        end
        S_NEXT: begin
          if (pass_r && (c_r == half + WW'(1)) && (y_r == '0)) begin
            state_r <= S_FIN;
          end else begin
            state_r <= S_CRD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid) begin
      op_r   <= in_ch.operation;
      col_r  <= in_ch.col;
      row_r  <= in_ch.row;
      cval_r <= in_ch.cell_value;
      sval_r <= in_ch.seed_value;
      wind_r <= in_ch.wind;
    end
    if (state_r == S_ADDR) begin
      addr_r   <= AW'(32'(row_r) * 32'(w_cur) + 32'(col_r));
      inside_r <= (32'(col_r) < 32'(w_cur)) && (32'(row_r) < 32'(h_cur));
    end
    if (state_r == S_RSTRT) begin
      w_r     <= w_cur;
      total_r <= (AW + 1)'(32'(w_cur) * 32'(h_cur));
      y_r     <= h_cur - HW'(2);
      c_r     <= '0;
      pass_r  <= 1'b0;
    end
    if (state_r == S_RINIT) begin
      rb_r <= AW'(total_r - (AW + 1)'(w_r) - (AW + 1)'(w_r));
    end
    if (state_r == S_CHK) begin
      v_r <= ram_rdata;
    end
    if (state_r == S_L2) begin
      r3_r <= fhr_pkg::mod3(seed_r);
    end
    if (state_r == S_L3) begin
      r2_r <= seed_r[0];
    end
    if (state_r == S_NEXT) begin
      if (!pass_r) begin
        if (c_r == half) begin
          pass_r <= 1'b1;
          c_r    <= w_r - WW'(1);
        end else begin
          c_r <= c_r + WW'(1);
        end
      end else if (c_r == half + WW'(1)) begin
        pass_r <= 1'b0;
        c_r    <= '0;
        y_r    <= y_r - HW'(1);
        rb_r   <= rb_r - AW'(w_r);
      end else begin
        c_r <= c_r - WW'(1);
      end
    end
    if (state_r == S_FIN && (!out_valid_r || out_ch.ready)) begin
      out_rd_r   <= rd_r;
      out_seed_r <= seed_r;
    end
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_rd_r;
  assign out_ch.seed_now   = out_seed_r;

endmodule
